// ----- sv/pure_pursuit_steering_macros.svh -----
// assertion macros shared by the checker file
`ifndef PURE_PURSUIT_STEERING_MACROS_SVH
`define PURE_PURSUIT_STEERING_MACROS_SVH

// same-cycle implication, silent during reset
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, silent during reset
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

  // waypoint table size and index widths
  localparam int MAX_WAYPOINTS = 1024;
  localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);

  // table entry layout: x, y, speed
  localparam int COORD_W = 32;
  localparam int SPEED_W = 16;
  localparam int ENTRY_W = 2 * COORD_W + SPEED_W;

  // datapath widths
  localparam int CFG_W  = 20;
  localparam int L2_W   = 2 * CFG_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int ROT_W  = 23;
  localparam int PROD_W = ROT_W + DIFF_W;
  localparam int Y_W    = PROD_W + 1;
  localparam int YLO_W  = 29;
  localparam int G2_W   = CFG_W + 1;
  localparam int NUM_W  = G2_W + Y_W;
  localparam int Q_W    = 32;

  // configuration register indexes
  localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_WALK_ASC  = 2'd2;
  localparam logic [1:0] REG_ACTIVE    = 2'd3;

  // request kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_POSE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEAR,
    ST_WALK,
    ST_ROT,
    ST_YSUM,
    ST_GAIN,
    ST_GSUM,
    ST_DIV,
    ST_DONE
  } state_t;

  // divider status back to the top level
  typedef struct packed {
    logic             done;
    logic             over;
    logic [Q_W-1:0]   quot;
  } div_res_t;

endpackage

// ----- sv/pps_wp_ram.sv -----
// ----------------------------------------------------------------------------
// pps_wp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pps_wp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pps_divider.sv -----
// ----------------------------------------------------------------------------
// pps_divider
// Restoring divider, one numerator bit per cycle, flags quotient overflow.
// ----------------------------------------------------------------------------
module pps_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [pps_pkg::NUM_W-1:0] num,
  input  logic [pps_pkg::L2_W-1:0]  den,
  output pps_pkg::div_res_t         res
);

  localparam int BIT_W = $clog2(pps_pkg::NUM_W);

  logic                      running;
  logic [BIT_W-1:0]          bidx;
  logic [pps_pkg::NUM_W-1:0] nsh;
  logic [pps_pkg::L2_W-1:0]  rem;
  logic [pps_pkg::L2_W-1:0]  dsr;
  logic [pps_pkg::Q_W-1:0]   quot;
  logic                      over;
  logic                      done;
  logic [pps_pkg::L2_W:0]    trial;
  logic                      ge;
  logic [pps_pkg::L2_W:0]    diff;

  // one trial subtraction
  always_comb begin
    trial = {rem, nsh[pps_pkg::NUM_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && bidx == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      bidx <= BIT_W'(pps_pkg::NUM_W - 1);
      nsh  <= num;
      dsr  <= (den == '0) ? pps_pkg::L2_W'(1) : den;
      rem  <= '0;
      quot <= '0;
      over <= 1'b0;
    end else if (running) begin
      bidx <= bidx - 1'b1;
      nsh  <= {nsh[pps_pkg::NUM_W-2:0], 1'b0};
      rem  <= ge ? diff[pps_pkg::L2_W-1:0] : trial[pps_pkg::L2_W-1:0];
      if (bidx >= BIT_W'(pps_pkg::Q_W)) begin
        over <= over | ge;
      end else begin
        quot <= {quot[pps_pkg::Q_W-2:0], ge};
      end
    end
  end

  assign res.done = done;
  assign res.over = over;
  assign res.quot = quot;

endmodule

// ----- sv/pure_pursuit_steering.sv -----
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Waypoint table with nearest search, lookahead walk and steering command.
// ----------------------------------------------------------------------------
// A write request (action 0) stores one waypoint and gives no result. A
// pose request (action 1) keeps busy high while it works, N being the
// active waypoint count: the nearest search reads all N entries through
// the single table read port, one per cycle, the lookahead walk reads up
// to N more, and a 78-step restoring divider forms the steering value.
// The result is registered on the output ports and marked by done for one
// cycle; it cannot be held off, so capture it then.
// Configuration writes are always ready and belong between requests.
module pure_pursuit_steering (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [pps_pkg::IDX_W-1:0]   slot,
  input  logic signed [31:0]          x_coord,
  input  logic signed [31:0]          y_coord,
  input  logic [15:0]                 speed,
  input  logic signed [15:0]          quat_w,
  input  logic signed [15:0]          quat_x,
  input  logic signed [15:0]          quat_y,
  input  logic signed [15:0]          quat_z,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [pps_pkg::CFG_W-1:0]   cfg_data,
  output logic                        done,
  output logic signed [31:0]          steering,
  output logic [15:0]                 drive_speed,
  output logic [pps_pkg::IDX_W-1:0]   nearest_slot,
  output logic [pps_pkg::IDX_W-1:0]   target_slot,
  output logic                        target_found,
  output logic                        steer_saturated
);

  localparam int IW = pps_pkg::IDX_W;
  localparam int CW = pps_pkg::CNT_W;

  pps_pkg::state_t state, state_next;

  // configuration
  logic [pps_pkg::CFG_W-1:0] lookahead;
  logic [pps_pkg::CFG_W-1:0] gain;
  logic                      walk_asc;
  logic [CW-1:0]             active;
  logic [pps_pkg::L2_W-1:0]  l2;
  logic [CW-1:0]             n_eff;

  // pose
  logic signed [31:0] px, py;
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [pps_pkg::ROT_W-1:0] r01, r11;

  // table access and scan pipeline
  logic                         accept, wr_req, issue;
  logic [pps_pkg::ENTRY_W-1:0]  rd_data;
  logic [IW-1:0]                iss_idx, iss_idx_next;
  logic [CW-1:0]                iss_cnt, ev_cnt;
  logic                         v1, v2, v3;
  logic [IW-1:0]                t1_idx, t2_idx, t3_idx;
  logic signed [pps_pkg::DIFF_W-1:0] dx2, dy2, dx3, dy3;
  logic [15:0]                  spd2, spd3;
  logic [pps_pkg::SQ_W-1:0]     sx3, sy3;
  logic [pps_pkg::DIFF_W-2:0]   ax2, ay2;
  logic [pps_pkg::DIST_W-1:0]   dsq;
  logic                         near_upd, far_enough, scan_last;

  // nearest and target
  logic [pps_pkg::DIST_W-1:0]        best;
  logic [IW-1:0]                     near, tgt;
  logic signed [pps_pkg::DIFF_W-1:0] near_dx, near_dy, tdx, tdy;
  logic [15:0]                       near_spd;
  logic                              found;

  // steering arithmetic
  logic signed [pps_pkg::PROD_W-1:0] pr01, pr11;
  logic signed [pps_pkg::Y_W-1:0]    yl;
  logic [pps_pkg::Y_W-1:0]           ay;
  logic                              neg;
  logic [pps_pkg::G2_W-1:0]          g2;
  logic [pps_pkg::G2_W+pps_pkg::YLO_W-1:0]           plo;
  logic [pps_pkg::G2_W+pps_pkg::Y_W-pps_pkg::YLO_W-1:0] phi;
  logic [pps_pkg::NUM_W-1:0]         num;
  logic                              div_go;
  pps_pkg::div_res_t                 div_res;

  // rotation terms
  logic signed [31:0] pxy, pwz, pxx, pzz;
  logic signed [34:0] v01, v11;

  assign busy      = (state != pps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_req    = accept && (action == pps_pkg::ACT_WRITE);
  assign done      = (state == pps_pkg::ST_DONE);

  // effective active count, clamped to the table, zero taken as one
  always_comb begin
    if (active == '0) begin
      n_eff = CW'(1);
    end else if (active > CW'(pps_pkg::MAX_WAYPOINTS)) begin
      n_eff = CW'(pps_pkg::MAX_WAYPOINTS);
    end else begin
      n_eff = active;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= pps_pkg::CFG_W'(65536);
      gain      <= pps_pkg::CFG_W'(32768);
      walk_asc  <= 1'b1;
      active    <= CW'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pps_pkg::REG_LOOKAHEAD: lookahead <= cfg_data;
        pps_pkg::REG_GAIN:      gain      <= cfg_data;
        pps_pkg::REG_WALK_ASC:  walk_asc  <= cfg_data[0];
        pps_pkg::REG_ACTIVE:    active    <= cfg_data[CW-1:0];
        default:                ;
      endcase
    end
  end

  // squared lookahead
  always_ff @(posedge clk) begin
    l2 <= lookahead * lookahead;
  end

  // rotation matrix terms, Q28 rounded to Q16
  always_comb begin
    pxy = qx * qy;
    pwz = qw * qz;
    pxx = qx * qx;
    pzz = qz * qz;
  end

  always_ff @(posedge clk) begin
    v01 <= ((35'(pxy) - 35'(pwz)) <<< 1) + 35'sd2048;
    v11 <= 35'sd268435456 - ((35'(pxx) + 35'(pzz)) <<< 1) + 35'sd2048;
    r01 <= v01[34:12];
    r11 <= v11[34:12];
  end

  // waypoint table
  pps_wp_ram #(
    .WIDTH (pps_pkg::ENTRY_W),
    .DEPTH (pps_pkg::MAX_WAYPOINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_req),
    .waddr (slot),
    .wdata ({x_coord, y_coord, speed}),
    .re    (issue),
    .raddr (iss_idx),
    .rdata (rd_data)
  );

  // read issue and walk stepping
  always_comb begin
    issue = ((state == pps_pkg::ST_NEAR) || (state == pps_pkg::ST_WALK))
            && (iss_cnt < n_eff);
    if (state == pps_pkg::ST_NEAR || walk_asc) begin
      iss_idx_next = (CW'(iss_idx) + CW'(1) >= n_eff) ? '0 : iss_idx + 1'b1;
    end else begin
      iss_idx_next = (iss_idx == '0) ? IW'(n_eff - CW'(1)) : iss_idx - 1'b1;
    end
  end

  // distance evaluation at the end of the scan pipeline
  always_comb begin
    ax2        = dx2[pps_pkg::DIFF_W-1] ? IW'(0) | 32'(-dx2) : 32'(dx2);
    ay2        = dy2[pps_pkg::DIFF_W-1] ? IW'(0) | 32'(-dy2) : 32'(dy2);
    dsq        = {1'b0, sx3} + {1'b0, sy3};
    near_upd   = (ev_cnt == '0) || (dsq < best);
    far_enough = dsq >= pps_pkg::DIST_W'(l2);
    scan_last  = (ev_cnt == n_eff - CW'(1));
  end

  // scan pipeline: data arrive, differences, squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t1_idx <= iss_idx;
    t2_idx <= t1_idx;
    t3_idx <= t2_idx;
    dx2    <= pps_pkg::DIFF_W'(signed'(rd_data[79:48])) - pps_pkg::DIFF_W'(px);
    dy2    <= pps_pkg::DIFF_W'(signed'(rd_data[47:16])) - pps_pkg::DIFF_W'(py);
    spd2   <= rd_data[15:0];
    dx3    <= dx2;
    dy3    <= dy2;
    spd3   <= spd2;
    sx3    <= ax2 * ax2;
    sy3    <= ay2 * ay2;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider kick
  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (accept && action == pps_pkg::ACT_POSE) begin
          state_next = pps_pkg::ST_NEAR;
        end
      end
      pps_pkg::ST_NEAR: begin
        if (v3 && scan_last) begin
          state_next = pps_pkg::ST_WALK;
        end
      end
      pps_pkg::ST_WALK: begin
        if (v3 && (far_enough || scan_last)) begin
          state_next = pps_pkg::ST_ROT;
        end
      end
      pps_pkg::ST_ROT:  state_next = pps_pkg::ST_YSUM;
      pps_pkg::ST_YSUM: state_next = pps_pkg::ST_GAIN;
      pps_pkg::ST_GAIN: state_next = pps_pkg::ST_GSUM;
      pps_pkg::ST_GSUM: begin
        div_go     = 1'b1;
        state_next = pps_pkg::ST_DIV;
      end
      pps_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = pps_pkg::ST_DONE;
        end
      end
      pps_pkg::ST_DONE: state_next = pps_pkg::ST_IDLE;
      default:          state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // pose capture, searches and steering datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cnt <= '0;
      ev_cnt  <= '0;
    end else begin
      if (issue) begin
        iss_cnt <= iss_cnt + CW'(1);
        iss_idx <= iss_idx_next;
      end
      unique case (state)
        pps_pkg::ST_IDLE: begin
          iss_cnt <= '0;
          ev_cnt  <= '0;
          iss_idx <= '0;
          if (accept) begin
            px <= x_coord;
            py <= y_coord;
            qw <= quat_w;
            qx <= quat_x;
            qy <= quat_y;
            qz <= quat_z;
          end
        end
        pps_pkg::ST_NEAR: begin
          if (v3) begin
            ev_cnt <= ev_cnt + CW'(1);
            if (near_upd) begin
              best     <= dsq;
              near     <= t3_idx;
              near_dx  <= dx3;
              near_dy  <= dy3;
              near_spd <= spd3;
            end
            if (scan_last) begin
              iss_cnt <= '0;
              ev_cnt  <= '0;
              iss_idx <= near_upd ? t3_idx : near;
            end
          end
        end
        pps_pkg::ST_WALK: begin
          if (v3) begin
            ev_cnt <= ev_cnt + CW'(1);
            if (far_enough) begin
              found <= 1'b1;
              tgt   <= t3_idx;
              tdx   <= dx3;
              tdy   <= dy3;
            end else if (scan_last) begin
              found <= 1'b0;
              tgt   <= near;
              tdx   <= near_dx;
              tdy   <= near_dy;
            end
          end
        end
        pps_pkg::ST_ROT: begin
          pr01 <= r01 * tdx;
          pr11 <= r11 * tdy;
        end
        pps_pkg::ST_YSUM: begin
          yl <= pps_pkg::Y_W'(pr01) + pps_pkg::Y_W'(pr11);
        end
        pps_pkg::ST_GAIN: begin
          neg <= yl[pps_pkg::Y_W-1];
          plo <= g2 * ay[pps_pkg::YLO_W-1:0];
          phi <= g2 * ay[pps_pkg::Y_W-1:pps_pkg::YLO_W];
        end
        pps_pkg::ST_DIV: begin
          if (div_res.done) begin
            drive_speed  <= near_spd;
            nearest_slot <= near;
            target_slot  <= tgt;
            target_found <= found;
            if (neg) begin
              if (div_res.over || div_res.quot > 32'h8000_0000) begin
                steering        <= 32'sh8000_0000;
                steer_saturated <= 1'b1;
              end else begin
                steering        <= signed'(32'h0 - div_res.quot);
                steer_saturated <= 1'b0;
              end
            end else begin
              if (div_res.over || div_res.quot[31]) begin
                steering        <= 32'sh7FFF_FFFF;
                steer_saturated <= 1'b1;
              end else begin
                steering        <= signed'(div_res.quot);
                steer_saturated <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // magnitude of the lateral offset, doubled gain and divider numerator
  always_comb begin
    ay  = yl[pps_pkg::Y_W-1] ? unsigned'(-yl) : unsigned'(yl);
    g2  = {gain, 1'b0};
    num = {phi, pps_pkg::YLO_W'(0)} + pps_pkg::NUM_W'(plo);
  end

  pps_divider u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (num),
    .den (l2),
    .res (div_res)
  );

endmodule

// ----- sv/pps_checker.sv -----
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "pure_pursuit_steering_macros.svh"

module pps_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      action,
  input logic                      done,
  input logic [pps_pkg::IDX_W-1:0] nearest_slot,
  input logic [pps_pkg::IDX_W-1:0] target_slot,
  input logic                      target_found
);

  // a result only appears while a pose request is in work
  `PPS_ASSERT_NOW(a_done_busy, done, busy, "result strobe without busy")

  // a table write gives no result
  `PPS_ASSERT_NEXT(a_write_silent, start && !busy && action == pps_pkg::ACT_WRITE,
    !done && !busy, "table write produced a result or busy")

  // a pose request starts work at once
  `PPS_ASSERT_NEXT(a_pose_busy, start && !busy && action == pps_pkg::ACT_POSE, busy,
    "pose request did not raise busy")

  // one strobe per pose
  `PPS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

  // with no target the walk falls back to the nearest entry
  `PPS_ASSERT_NOW(a_fallback, done && !target_found, target_slot == nearest_slot,
    "target differs from nearest without a found target")

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (.*);
